### rtl/assert_macros.svh
// Assertion helpers used by dltq_seq.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DLTQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define DLTQ_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define DLTQ_ASSERT(lbl, clk, rstn, prop, msg)
`define DLTQ_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

### rtl/dltq_pkg.sv
`default_nettype none
package dltq_pkg;

  localparam int CAPACITY    = 16;
  localparam int HANDLE_BITS = 16;
  localparam int MAX_OUT     = 16;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int FIRE_W      = $clog2(MAX_OUT + 1);

  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_DEL  = 2'd1,
    KIND_TICK = 2'd2,
    KIND_NOP  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    RES_ADDED     = 3'd0,
    RES_FULL      = 3'd1,
    RES_DELETED   = 3'd2,
    RES_NOT_FOUND = 3'd3,
    RES_EXPIRY    = 3'd4
  } res_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P_SCAN,
    ST_P_CMP,
    ST_S_RD,
    ST_S_WR,
    ST_P_NEW,
    ST_D_SCAN,
    ST_D_CMP,
    ST_R_RD,
    ST_R_WR,
    ST_T_HEAD,
    ST_T_NEXT,
    ST_T_END
  } state_e;

  typedef struct packed {
    logic [31:0]            delta;
    logic [31:0]            period;
    logic [31:0]            tag;
    logic [HANDLE_BITS-1:0] handle;
    logic                   once;
  } entry_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
  } mem_req_t;

  typedef struct packed {
    logic        valid;
    res_kind_e   kind;
    logic [15:0] handle;
    logic [31:0] tag;
    logic        last;
  } result_t;

  // Low 16 bits of a stored handle, zero-extended when handles are narrower.
  function automatic logic [15:0] handle16(input logic [HANDLE_BITS-1:0] h);
    logic [31:0] w;
    w = 32'(h);
    return w[15:0];
  endfunction

endpackage
`default_nettype wire

### rtl/dltq_ram.sv
`default_nettype none
module dltq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one word, read one word with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### rtl/dltq_seq.sv
`default_nettype none
`include "assert_macros.svh"
module dltq_seq (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic [1:0]           kind_i,
  input  wire logic [31:0]          period_i,
  input  wire logic                 one_shot_i,
  input  wire logic [31:0]          tag_i,
  input  wire logic [15:0]          target_handle_i,
  output dltq_pkg::mem_req_t        mem_req_o,
  input  wire dltq_pkg::entry_t     rdata_i,
  output dltq_pkg::result_t         res_o
);
  import dltq_pkg::*;

  state_e                 state_q, state_d;
  kind_e                  op_q, op_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [HANDLE_BITS-1:0] next_handle_q, next_handle_d;
  logic [CNT_W-1:0]       idx_q, idx_d;
  logic [CNT_W-1:0]       pos_q, pos_d;
  logic [31:0]            rem_q, rem_d;
  logic [31:0]            ne_period_q, ne_period_d;
  logic [31:0]            ne_tag_q, ne_tag_d;
  logic [HANDLE_BITS-1:0] ne_handle_q, ne_handle_d;
  logic                   ne_once_q, ne_once_d;
  logic [31:0]            cd_q, cd_d;
  logic                   first_q, first_d;
  logic                   dec_q, dec_d;
  logic [FIRE_W-1:0]      fires_q, fires_d;
  logic                   pend_valid_q, pend_valid_d;
  logic [15:0]            pend_handle_q, pend_handle_d;
  logic [31:0]            pend_tag_q, pend_tag_d;
  logic [15:0]            target_q, target_d;

  assign busy_o = (state_q != ST_IDLE);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      next_handle_q <= '0;
      pend_valid_q  <= 1'b0;
      first_q       <= 1'b0;
      dec_q         <= 1'b0;
      fires_q       <= '0;
      op_q          <= KIND_NOP;
    end else begin
      state_q       <= state_d;
      count_q       <= count_d;
      next_handle_q <= next_handle_d;
      pend_valid_q  <= pend_valid_d;
      first_q       <= first_d;
      dec_q         <= dec_d;
      fires_q       <= fires_d;
      op_q          <= op_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    idx_q         <= idx_d;
    pos_q         <= pos_d;
    rem_q         <= rem_d;
    ne_period_q   <= ne_period_d;
    ne_tag_q      <= ne_tag_d;
    ne_handle_q   <= ne_handle_d;
    ne_once_q     <= ne_once_d;
    cd_q          <= cd_d;
    pend_handle_q <= pend_handle_d;
    pend_tag_q    <= pend_tag_d;
    target_q      <= target_d;
  end

  // Sequence list walks, shifts and read-modify-writes
  always_comb begin
    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] idx_dec;
    logic [31:0]      new_delta;
    entry_t           wr;
    state_d       = state_q;
    op_d          = op_q;
    count_d       = count_q;
    next_handle_d = next_handle_q;
    idx_d         = idx_q;
    pos_d         = pos_q;
    rem_d         = rem_q;
    ne_period_d   = ne_period_q;
    ne_tag_d      = ne_tag_q;
    ne_handle_d   = ne_handle_q;
    ne_once_d     = ne_once_q;
    cd_d          = cd_q;
    first_d       = first_q;
    dec_d         = dec_q;
    fires_d       = fires_q;
    pend_valid_d  = pend_valid_q;
    pend_handle_d = pend_handle_q;
    pend_tag_d    = pend_tag_q;
    target_d      = target_q;
    mem_req_o     = '0;
    res_o         = '0;
    idx_inc       = idx_q + 1'b1;
    idx_dec       = idx_q - 1'b1;
    new_delta     = rdata_i.delta;
    wr            = rdata_i;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d     = kind_e'(kind_i);
          target_d = target_handle_i;
          case (kind_e'(kind_i))
            KIND_ADD: begin
              if (count_q == CNT_W'(CAPACITY)) begin
                res_o.valid = 1'b1;
                res_o.kind  = RES_FULL;
                res_o.last  = 1'b1;
              end else begin
                ne_period_d = (period_i == 32'd0) ? 32'd1 : period_i;
                rem_d       = (period_i == 32'd0) ? 32'd1 : period_i;
                ne_tag_d    = tag_i;
                ne_handle_d = next_handle_q;
                ne_once_d   = one_shot_i;
                idx_d       = '0;
                state_d     = ST_P_SCAN;
              end
            end
            KIND_DEL: begin
              idx_d   = '0;
              state_d = ST_D_SCAN;
            end
            KIND_TICK: begin
              if (count_q != '0) begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = '0;
                dec_d           = 1'b1;
                fires_d         = '0;
                pend_valid_d    = 1'b0;
                state_d         = ST_T_HEAD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Walk to the insertion point
      ST_P_SCAN: begin
        if (idx_q == count_q) begin
          pos_d   = idx_q;
          state_d = ST_P_NEW;
        end else begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = idx_q[IDX_W-1:0];
          state_d         = ST_P_CMP;
        end
      end

      ST_P_CMP: begin
        if (rem_q >= rdata_i.delta) begin
          rem_d   = rem_q - rdata_i.delta;
          idx_d   = idx_inc;
          state_d = ST_P_SCAN;
        end else begin
          pos_d   = idx_q;
          idx_d   = count_q - 1'b1;
          state_d = ST_S_RD;
        end
      end

      // Shift the tail up by one, tail end first
      ST_S_RD: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = idx_q[IDX_W-1:0];
        state_d         = ST_S_WR;
      end

      ST_S_WR: begin
        if (idx_q == pos_q) begin
          wr.delta = rdata_i.delta - rem_q;
        end
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = idx_inc[IDX_W-1:0];
        mem_req_o.wdata = wr;
        if (idx_q == pos_q) begin
          state_d = ST_P_NEW;
        end else begin
          idx_d   = idx_dec;
          state_d = ST_S_RD;
        end
      end

      ST_P_NEW: begin
        mem_req_o.we           = 1'b1;
        mem_req_o.waddr        = pos_q[IDX_W-1:0];
        mem_req_o.wdata.delta  = rem_q;
        mem_req_o.wdata.period = ne_period_q;
        mem_req_o.wdata.tag    = ne_tag_q;
        mem_req_o.wdata.handle = ne_handle_q;
        mem_req_o.wdata.once   = ne_once_q;
        count_d                = count_q + 1'b1;
        if (op_q == KIND_ADD) begin
          res_o.valid   = 1'b1;
          res_o.kind    = RES_ADDED;
          res_o.handle  = handle16(ne_handle_q);
          res_o.last    = 1'b1;
          next_handle_d = next_handle_q + 1'b1;
          state_d       = ST_IDLE;
        end else begin
          state_d = ST_T_NEXT;
        end
      end

      // Search by handle
      ST_D_SCAN: begin
        if (idx_q == count_q) begin
          res_o.valid  = 1'b1;
          res_o.kind   = RES_NOT_FOUND;
          res_o.handle = target_q;
          res_o.last   = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = idx_q[IDX_W-1:0];
          state_d         = ST_D_CMP;
        end
      end

      ST_D_CMP: begin
        idx_d = idx_inc;
        if (handle16(rdata_i.handle) == target_q) begin
          cd_d    = rdata_i.delta;
          first_d = 1'b1;
          state_d = ST_R_RD;
        end else begin
          state_d = ST_D_SCAN;
        end
      end

      // Shift the tail down by one, folding the removed delta into the successor
      ST_R_RD: begin
        if (idx_q == count_q) begin
          count_d = count_q - 1'b1;
          if (op_q == KIND_DEL) begin
            res_o.valid  = 1'b1;
            res_o.kind   = RES_DELETED;
            res_o.handle = target_q;
            res_o.last   = 1'b1;
            state_d      = ST_IDLE;
          end else if (!ne_once_q) begin
            rem_d   = ne_period_q;
            idx_d   = '0;
            state_d = ST_P_SCAN;
          end else begin
            state_d = ST_T_NEXT;
          end
        end else begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = idx_q[IDX_W-1:0];
          state_d         = ST_R_WR;
        end
      end

      ST_R_WR: begin
        if (first_q) begin
          wr.delta = rdata_i.delta + cd_q;
        end
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = idx_dec[IDX_W-1:0];
        mem_req_o.wdata = wr;
        first_d         = 1'b0;
        idx_d           = idx_inc;
        state_d         = ST_R_RD;
      end

      // Decrement the head once per tick, then fire zero-delta heads
      ST_T_HEAD: begin
        dec_d = 1'b0;
        if (dec_q && (rdata_i.delta != 32'd0)) begin
          new_delta             = rdata_i.delta - 32'd1;
          wr.delta              = new_delta;
          mem_req_o.we          = 1'b1;
          mem_req_o.waddr       = '0;
          mem_req_o.wdata       = wr;
        end
        if (new_delta == 32'd0) begin
          if (pend_valid_q) begin
            res_o.valid  = 1'b1;
            res_o.kind   = RES_EXPIRY;
            res_o.handle = pend_handle_q;
            res_o.tag    = pend_tag_q;
          end
          pend_valid_d  = 1'b1;
          pend_handle_d = handle16(rdata_i.handle);
          pend_tag_d    = rdata_i.tag;
          ne_period_d   = (rdata_i.period == 32'd0) ? 32'd1 : rdata_i.period;
          ne_tag_d      = rdata_i.tag;
          ne_handle_d   = rdata_i.handle;
          ne_once_d     = rdata_i.once;
          fires_d       = fires_q + 1'b1;
          cd_d          = '0;
          first_d       = 1'b1;
          idx_d         = CNT_W'(1);
          state_d       = ST_R_RD;
        end else begin
          state_d = ST_T_END;
        end
      end

      ST_T_NEXT: begin
        if ((count_q == '0) || (fires_q == FIRE_W'(MAX_OUT))) begin
          state_d = ST_T_END;
        end else begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = '0;
          state_d         = ST_T_HEAD;
        end
      end

      // Flush the held expiry as the final word
      ST_T_END: begin
        if (pend_valid_q) begin
          res_o.valid  = 1'b1;
          res_o.kind   = RES_EXPIRY;
          res_o.handle = pend_handle_q;
          res_o.tag    = pend_tag_q;
          res_o.last   = 1'b1;
        end
        pend_valid_d = 1'b0;
        state_d      = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `DLTQ_ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > CNT_W'(CAPACITY), "count overflow")
  `DLTQ_ASSERT_NEVER(a_rw_clash, clk_i, rst_ni, mem_req_o.we && mem_req_o.re && (mem_req_o.waddr == mem_req_o.raddr), "read and write hit one entry")
  `DLTQ_ASSERT(a_fire_cap, clk_i, rst_ni, (state_q == ST_T_HEAD) |-> (fires_q < FIRE_W'(MAX_OUT)), "too many expiries")
  `DLTQ_ASSERT(a_idle_res, clk_i, rst_ni, (res_o.valid && res_o.last) |=> (state_q == ST_IDLE), "final word outside idle return")

endmodule
`default_nettype wire

### rtl/delta_list_timer_queue_core.sv
`default_nettype none
// Delta-list timer queue.
// Request channel: raise start with kind_i and its fields; the word is taken
// at a rising edge where start is high and busy is low. busy stays high until
// the request is fully handled.
// Result channel: result_valid_o marks each result word for one cycle,
// result_kind_o/handle_o/fired_tag_o carry it, last_o marks the final word
// of a request. The receiver cannot stall; every word must be taken.
// All list state sits in one RAM with a registered read, so every list
// entry visited takes a read state and then a compare or write state.
// Add: walks the list to the insertion point, shifts the tail up and writes
// the new entry; an add to a full store answers without raising busy.
// Delete: searches by handle, then shifts the tail down over the entry.
// Tick: fetch and check each head, per expiry a removal shift and, for
// periodic timers, a re-insertion as for add; up to 16 expiries per tick,
// then a final state flushes the last word.
// An empty tick gives no word and leaves busy low; a tick with no expiry
// gives no word.
// The result word leaves through an output register, in the cycle after it
// is formed. Reset clears the count and handle counter; RAM needs no clear.
module delta_list_timer_queue_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  kind_i,
  input  wire logic [31:0] period_i,
  input  wire logic        one_shot_i,
  input  wire logic [31:0] tag_i,
  input  wire logic [15:0] target_handle_i,
  output logic             result_valid_o,
  output logic [2:0]       result_kind_o,
  output logic [15:0]      handle_o,
  output logic [31:0]      fired_tag_o,
  output logic             last_o
);
  import dltq_pkg::*;

  mem_req_t mem_req;
  entry_t   rdata;
  result_t  res;
  logic     valid_q;
  result_t  res_q;

  dltq_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_o          (busy),
    .kind_i          (kind_i),
    .period_i        (period_i),
    .one_shot_i      (one_shot_i),
    .tag_i           (tag_i),
    .target_handle_i (target_handle_i),
    .mem_req_o       (mem_req),
    .rdata_i         (rdata),
    .res_o           (res)
  );

  dltq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  // Register the result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res;
  end

  assign result_valid_o = valid_q;
  assign result_kind_o  = res_q.kind;
  assign handle_o       = res_q.handle;
  assign fired_tag_o    = res_q.tag;
  assign last_o         = res_q.last;

endmodule
`default_nettype wire
